// ===== design/vma_pkg.sv =====
// Shared types and constants for the vector moving average block.
`timescale 1ns / 1ps

package vma_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int NUM_CH         = 4;
  localparam int WIN_W          = 8;
  localparam int USED_W         = 5;
  localparam int MAX_WINDOW_DEF = 16;

  localparam logic [WIN_W-1:0] WIN_RESET = 8'd3;

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_BAD_WINDOW = 1'b1;

  typedef struct packed {
    logic                       clear_history;
    logic signed [SAMPLE_W-1:0] sample_ch0;
    logic signed [SAMPLE_W-1:0] sample_ch1;
    logic signed [SAMPLE_W-1:0] sample_ch2;
    logic signed [SAMPLE_W-1:0] sample_ch3;
  } vma_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_ch0;
    logic signed [SAMPLE_W-1:0] mean_ch1;
    logic signed [SAMPLE_W-1:0] mean_ch2;
    logic signed [SAMPLE_W-1:0] mean_ch3;
    logic [USED_W-1:0]          samples_used;
    logic                       result_valid;
    logic                       error_flag;
    logic                       status_code;
  } vma_out_t;

endpackage

// ===== design/vma_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module vma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/vma_div.sv =====
// Multi-lane signed divider, restoring, one quotient bit per cycle per lane.
`timescale 1ns / 1ps

module vma_div #(
  parameter int DW    = 21,
  parameter int CW    = 5,
  parameter int LANES = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [DW-1:0]                  dividend [LANES],
  input  logic [CW-1:0]                         divisor,
  output logic                                  done,
  output logic signed [vma_pkg::SAMPLE_W-1:0]   quotient [LANES]
);

  import vma_pkg::*;

  localparam int STEP_W = $clog2(DW + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CW-1:0]     dsr_r;
  logic [DW-1:0]     q_r    [LANES];
  logic [CW:0]       rem_r  [LANES];
  logic              neg_r  [LANES];
  logic [DW-1:0]     q_nxt  [LANES];
  logic [CW:0]       rem_nxt[LANES];

  // One restoring step per lane; the lanes share only the divisor.
  always_comb begin
    logic [CW:0] shifted;
    logic [CW:0] diff;
    for (int l = 0; l < LANES; l++) begin
      shifted = {rem_r[l][CW-1:0], q_r[l][DW-1]};
      diff    = shifted - {1'b0, dsr_r};
      if (!diff[CW]) begin
        rem_nxt[l] = diff;
        q_nxt[l]   = {q_r[l][DW-2:0], 1'b1};
      end else begin
        rem_nxt[l] = shifted;
        q_nxt[l]   = {q_r[l][DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r <= divisor;
      for (int l = 0; l < LANES; l++) begin
        neg_r[l] <= dividend[l][DW-1];
        q_r[l]   <= dividend[l][DW-1] ? DW'(-dividend[l]) : DW'(dividend[l]);
        rem_r[l] <= '0;
      end
    end else if (busy_r) begin
      for (int l = 0; l < LANES; l++) begin
        q_r[l]   <= q_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
    end
  end

  // Sign is restored here; the quotient magnitude never exceeds 2^(SAMPLE_W-1).
  always_comb begin
    logic [DW-1:0] qs;
    for (int l = 0; l < LANES; l++) begin
      qs          = neg_r[l] ? (~q_r[l] + 1'b1) : q_r[l];
      quotient[l] = qs[SAMPLE_W-1:0];
    end
  end

  assign done = done_r;

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");

  a_start_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted mid-division");

  a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r) && $past(step_r) == STEP_W'(DW - 1))
    else $error("divider finished early");

endmodule

// ===== design/vector_moving_average.sv =====
// Top level of the four-channel moving average over a ring of Q8.8 vectors.
`timescale 1ns / 1ps

// Each accepted beat carries four signed Q8.8 samples and a clear flag. The
// vector is stored in a ring RAM of MAX_WINDOW entries (after emptying the
// history when clear_history is set), and one result beat follows with the
// per-channel mean of the newest min(stored count, window_length) vectors,
// truncated toward zero. The sums over the active vectors (the number
// averaged) are SUM_W bits wide, 21 bits for the default depth of 16.
// The single read port of the ring RAM returns one stored vector per
// cycle, and the divider produces one quotient bit per cycle for all
// four channels at once. Items are handled one at a time; a finished
// result sits in the output register, so the next beat can be accepted
// while it waits to be taken. A window_length of zero or above
// MAX_WINDOW gives an error beat with zero means and leaves the history
// untouched. The ring RAM has no reset: only entries written since the
// last clear or reset are ever read back.

module vector_moving_average #(
  parameter int MAX_WINDOW = vma_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  vma_pkg::vma_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output vma_pkg::vma_out_t              out_data,
  input  logic                           cfg_write_en,
  input  logic [vma_pkg::WIN_W-1:0]      cfg_write_data
);

  import vma_pkg::*;

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int RING_W = NUM_CH * SAMPLE_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WRITE  = 5'b00010,
    S_READ   = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } vma_state_t;

  vma_state_t state_r, state_nxt;

  logic [WIN_W-1:0]        win_r;
  logic [PTR_W-1:0]        wp_r;
  logic [CNT_W-1:0]        cnt_r;
  vma_in_t                 item_r;
  logic                    err_r;
  logic [CNT_W-1:0]        active_r;
  logic [PTR_W-1:0]        rd_ptr_r;
  logic [CNT_W-1:0]        issue_r;
  logic                    rd_vld_r;
  logic signed [SUM_W-1:0] sum_r [NUM_CH];
  logic                    out_valid_r;
  vma_out_t                out_r;

  logic                    in_fire;
  logic                    win_bad;
  logic                    issue_now;
  logic                    out_load;
  logic [PTR_W-1:0]        waddr;
  logic [PTR_W-1:0]        wp_nxt;
  logic [CNT_W-1:0]        cnt_nxt;
  logic [CNT_W-1:0]        active_nxt;
  logic [RING_W-1:0]       wdata;
  logic [RING_W-1:0]       rdata;
  logic signed [SAMPLE_W-1:0] samp [NUM_CH];
  logic                    div_start;
  logic                    div_done;
  logic signed [SAMPLE_W-1:0] mean [NUM_CH];

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign win_bad  = (win_r == '0) || (win_r > WIN_W'(MAX_WINDOW));

  // The new vector goes in at slot zero after a clear, otherwise at the
  // write pointer. The count saturates at the ring depth.
  assign samp[0] = item_r.sample_ch0;
  assign samp[1] = item_r.sample_ch1;
  assign samp[2] = item_r.sample_ch2;
  assign samp[3] = item_r.sample_ch3;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      wdata[c*SAMPLE_W +: SAMPLE_W] = samp[c];
    end
  end

  assign waddr  = item_r.clear_history ? '0 : wp_r;
  assign wp_nxt = (waddr == PTR_W'(MAX_WINDOW - 1)) ? '0 : waddr + 1'b1;

  always_comb begin
    if (item_r.clear_history) begin
      cnt_nxt = CNT_W'(1);
    end else if (cnt_r < CNT_W'(MAX_WINDOW)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
    active_nxt = (WIN_W'(cnt_nxt) < win_r) ? cnt_nxt : CNT_W'(win_r);
  end

  // Reads walk backwards from the entry just written, one address a cycle.
  // The write lands in the cycle before the first read, so no forwarding is needed.
  assign issue_now = (state_r == S_READ) && (issue_r < active_r);
  assign div_start = (state_r == S_READ) && (issue_r == active_r) && !rd_vld_r;
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  vma_ram #(
    .WIDTH (RING_W),
    .DEPTH (MAX_WINDOW),
    .AW    (PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == S_WRITE),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

  vma_div #(
    .DW    (SUM_W),
    .CW    (CNT_W),
    .LANES (NUM_CH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (active_r),
    .done     (div_done),
    .quotient (mean)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = win_bad ? S_FINISH : S_WRITE;
        end
      end
      S_WRITE:  state_nxt = S_READ;
      S_READ: begin
        if (div_start) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WIN_RESET;
      wp_r        <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write_en) begin
        win_r <= cfg_write_data;
      end
      if (state_r == S_WRITE) begin
        wp_r  <= wp_nxt;
        cnt_r <= cnt_nxt;
      end
      rd_vld_r <= issue_now;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
      err_r  <= win_bad;
    end
    if (state_r == S_WRITE) begin
      active_r <= active_nxt;
      rd_ptr_r <= waddr;
      issue_r  <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        sum_r[c] <= '0;
      end
    end
    if (issue_now) begin
      issue_r  <= issue_r + 1'b1;
      rd_ptr_r <= (rd_ptr_r == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_ptr_r - 1'b1;
    end
    if (rd_vld_r) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sum_r[c] <= sum_r[c] + SUM_W'(signed'(rdata[c*SAMPLE_W +: SAMPLE_W]));
      end
    end
    if (out_load) begin
      if (err_r) begin
        out_r.mean_ch0     <= '0;
        out_r.mean_ch1     <= '0;
        out_r.mean_ch2     <= '0;
        out_r.mean_ch3     <= '0;
        out_r.samples_used <= '0;
        out_r.result_valid <= 1'b0;
        out_r.error_flag   <= 1'b1;
        out_r.status_code  <= STATUS_BAD_WINDOW;
      end else begin
        out_r.mean_ch0     <= mean[0];
        out_r.mean_ch1     <= mean[1];
        out_r.mean_ch2     <= mean[2];
        out_r.mean_ch3     <= mean[3];
        out_r.samples_used <= USED_W'(active_r);
        out_r.result_valid <= 1'b1;
        out_r.error_flag   <= 1'b0;
        out_r.status_code  <= STATUS_OK;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (issue_r <= active_r) && (active_r != '0)
      && (active_r <= CNT_W'(MAX_WINDOW)))
    else $error("ring read count out of range");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider result outside the divide phase");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CNT_W'(MAX_WINDOW)) && (wp_r <= PTR_W'(MAX_WINDOW - 1)))
    else $error("ring pointer or count out of range");

  a_error_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && win_bad) |=> $stable(wp_r) && $stable(cnt_r))
    else $error("history changed on a bad window");

endmodule
